[sv/pfp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the PWM channel-frame parser.
// No dependencies; used by every module of the block.
package pfp_pkg;

   // Default frame geometry
   localparam int CHANNEL_COUNT = 8;
   localparam int FRAME_BYTES   = 21;

   // Frames waiting between the parser and the result sequencer
   localparam int QUEUE_DEPTH = 2;

   // Frame header codes
   localparam logic [7:0] SOF_A     = 8'hAA;
   localparam logic [7:0] SOF_B     = 8'h55;
   localparam logic [7:0] HEADER_ID = 8'h01;

   // Duty mapping: (raw - 5000) / 5000 in Q1.15
   localparam logic [15:0] DUTY_CENTER = 16'd5000;
   localparam logic [15:0] DUTY_FULL   = 16'd10000;
   // |d| * 4096 / 625, rounded: bias of 312, then multiply by ceil(2^35 / 625)
   localparam logic [24:0] ROUND_BIAS  = 25'd312;
   localparam logic [25:0] DUTY_RECIP  = 26'd54975582;
   localparam int          RECIP_SHIFT = 35;
   localparam logic [15:0] DUTY_MAX    = 16'h7FFF;
   localparam logic [15:0] DUTY_MIN    = 16'h8000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       burst_end;
   } req_type;

   typedef struct packed {
      logic [2:0]         channel_index;
      logic [15:0]        raw_value;
      logic signed [15:0] duty_q15;
      logic               last_channel;
   } rsp_type;

endpackage

[sv/pfp_front.sv]
`timescale 1ns / 1ps
// Byte-stream front end: sliding window, running checksum and frame match.
// Depends on pfp_pkg.
module pfp_front #(
   parameter int CHANNEL_COUNT = pfp_pkg::CHANNEL_COUNT,
   parameter int FRAME_BYTES   = pfp_pkg::FRAME_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  pfp_pkg::req_type                req_data,
   output logic                            push,
   output logic [CHANNEL_COUNT-1:0][15:0]  frame
);

   localparam int         WIN_DEPTH = FRAME_BYTES - 1;
   localparam int         FILL_W    = $clog2(FRAME_BYTES);
   localparam logic [7:0] LEN_BYTE  = 8'(2 * CHANNEL_COUNT);

   logic [7:0]        win_ff [WIN_DEPTH];
   logic [7:0]        win_in [WIN_DEPTH];
   logic [7:0]        sum_ff;
   logic [7:0]        sum_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              win_full;
   logic              hit;

   assign win_full = (fill_ff == FILL_W'(WIN_DEPTH));

   assign hit = win_full
             && (win_ff[0] == pfp_pkg::SOF_A)
             && (win_ff[1] == pfp_pkg::SOF_B)
             && (win_ff[2] == pfp_pkg::HEADER_ID)
             && (win_ff[3] == LEN_BYTE)
             && (sum_ff == req_data.data_byte);

   assign push = accept && hit;

   // The newest byte always enters at the top; the fill count says how much is live
   always_comb begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[WIN_DEPTH-1] = req_data.data_byte;
   end

   always_comb begin
      priority if (fill_ff == '0) begin
         sum_in = req_data.data_byte;
      end else if (win_full) begin
         // slide: drop the oldest byte from the sum
         sum_in = sum_ff - win_ff[0] + req_data.data_byte;
      end else begin
         sum_in = sum_ff + req_data.data_byte;
      end
   end

   always_comb begin
      priority if (req_data.burst_end || hit) begin
         fill_in = '0;
      end else if (win_full) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
         sum_ff <= sum_in;
      end
   end

   // Channel bytes beyond the held window read as zero
   for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_chan
      localparam int HI = 4 + 2 * c;
      localparam int LO = 5 + 2 * c;
      if (HI < WIN_DEPTH) begin : g_hi
         assign frame[c][15:8] = win_ff[HI];
      end else begin : g_hi_zero
         assign frame[c][15:8] = '0;
      end
      if (LO < WIN_DEPTH) begin : g_lo
         assign frame[c][7:0] = win_ff[LO];
      end else begin : g_lo_zero
         assign frame[c][7:0] = '0;
      end
   end

`ifndef ASSERT_OFF
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN_DEPTH))
      else $error("fill count beyond window depth");
`endif

endmodule

[sv/pfp_queue.sv]
`timescale 1ns / 1ps
// Short queue of decoded frames between the parser and the result sequencer.
// Depends on pfp_pkg.
module pfp_queue #(
   parameter int CHANNEL_COUNT = pfp_pkg::CHANNEL_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic [CHANNEL_COUNT-1:0][15:0]  push_frame,
   input  logic                            pop,
   output logic                            head_valid,
   output logic [CHANNEL_COUNT-1:0][15:0]  head_frame,
   output logic                            full
);

   localparam int DEPTH = pfp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CHANNEL_COUNT-1:0][15:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]               wr_ptr_ff;
   logic [PTR_W-1:0]               rd_ptr_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_frame = slot_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |=> !(count_ff == '0) && (count_ff <= CNT_W'(DEPTH)))
      else $error("frame queue count out of range");
`endif

endmodule

[sv/pfp_back.sv]
`timescale 1ns / 1ps
// Result sequencer: walks the channels of the head frame and maps each raw
// value to a Q1.15 duty through a three-stage pipeline. Depends on pfp_pkg.
module pfp_back #(
   parameter int CHANNEL_COUNT = pfp_pkg::CHANNEL_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  logic [CHANNEL_COUNT-1:0][15:0]  q_frame,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pfp_pkg::rsp_type                rsp_data
);

   localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int X_W    = 25;
   localparam int PROD_W = 51;

   typedef struct packed {
      logic [2:0]  idx;
      logic        last;
      logic [15:0] raw;
      logic        neg;
      logic        sat_hi;
      logic        sat_lo;
   } tag_type;

   logic [CH_W-1:0]   ch_ff;
   logic              last_ch;
   logic              advance;

   logic              a_valid_ff;
   tag_type           a_tag_ff;
   tag_type           a_tag_in;
   logic [X_W-1:0]    a_x_ff;
   logic [X_W-1:0]    a_x_in;

   logic              b_valid_ff;
   tag_type           b_tag_ff;
   logic [PROD_W-1:0] b_prod_ff;
   logic [PROD_W-1:0] b_prod_in;

   logic              rsp_valid_ff;
   pfp_pkg::rsp_type  rsp_ff;
   pfp_pkg::rsp_type  rsp_in;

   logic [15:0]       raw;
   logic [15:0]       diff_hi;
   logic [15:0]       diff_lo;
   logic [12:0]       mag;
   logic [14:0]       quot;

   // The whole pipe moves when the output register is free or being drained
   assign advance = !rsp_valid_ff || rsp_ready;
   assign last_ch = (ch_ff == CH_W'(CHANNEL_COUNT - 1));
   assign q_pop   = advance && q_valid && last_ch;

   // Stage A: select channel, split into sign, magnitude and saturation
   assign raw     = q_frame[ch_ff];
   assign diff_hi = raw - pfp_pkg::DUTY_CENTER;
   assign diff_lo = pfp_pkg::DUTY_CENTER - raw;

   always_comb begin
      a_tag_in.idx    = 3'(ch_ff);
      a_tag_in.last   = last_ch;
      a_tag_in.raw    = raw;
      a_tag_in.neg    = (raw < pfp_pkg::DUTY_CENTER);
      a_tag_in.sat_hi = (raw >= pfp_pkg::DUTY_FULL);
      a_tag_in.sat_lo = (raw == '0);
      mag             = a_tag_in.neg ? diff_lo[12:0] : diff_hi[12:0];
      a_x_in          = {mag, 12'b0} + pfp_pkg::ROUND_BIAS;
   end

   // Stage B: divide by 625 through the reciprocal
   assign b_prod_in = a_x_ff * pfp_pkg::DUTY_RECIP;

   // Stage C: apply sign and clamp
   assign quot = b_prod_ff[pfp_pkg::RECIP_SHIFT +: 15];

   always_comb begin
      rsp_in.channel_index = b_tag_ff.idx;
      rsp_in.raw_value     = b_tag_ff.raw;
      rsp_in.last_channel  = b_tag_ff.last;
      priority if (b_tag_ff.sat_hi) begin
         rsp_in.duty_q15 = pfp_pkg::DUTY_MAX;
      end else if (b_tag_ff.sat_lo) begin
         rsp_in.duty_q15 = pfp_pkg::DUTY_MIN;
      end else if (b_tag_ff.neg) begin
         rsp_in.duty_q15 = 16'(16'd0 - {1'b0, quot});
      end else begin
         rsp_in.duty_q15 = {1'b0, quot};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff        <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         if (q_valid) begin
            ch_ff <= last_ch ? '0 : ch_ff + 1'b1;
         end
         a_valid_ff   <= q_valid;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_tag_ff  <= a_tag_in;
         a_x_ff    <= a_x_in;
         b_tag_ff  <= a_tag_ff;
         b_prod_ff <= b_prod_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_sat_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.raw_value >= pfp_pkg::DUTY_FULL)
      |-> (rsp_ff.duty_q15 == pfp_pkg::DUTY_MAX))
      else $error("duty not saturated for full-scale value");

   a_duty_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.duty_q15[15] == (rsp_ff.raw_value < pfp_pkg::DUTY_CENTER)))
      else $error("duty sign disagrees with raw value");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_channel |-> (rsp_ff.channel_index == 3'(CHANNEL_COUNT - 1)))
      else $error("last channel flag on wrong index");
`endif

endmodule

[sv/pwm_frame_parser.sv]
`timescale 1ns / 1ps
// PWM channel-frame parser, top level. Depends on pfp_pkg, pfp_front, pfp_queue, pfp_back.
// Throughput: one byte per cycle in while req_ready is high, one result per cycle out while rsp_ready is high.
// Path: once its checksum byte is taken, a frame goes through the queue write and then the
//   duty pipeline of select/multiply/clamp to its first result.
// req_ready drops only while the frame queue holds two frames not yet fully sent.
// Reset clears the fill count, the frame queue and the pipeline; the window needs no clear.
module pwm_frame_parser #(
   parameter int CHANNEL_COUNT = pfp_pkg::CHANNEL_COUNT,
   parameter int FRAME_BYTES   = pfp_pkg::FRAME_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfp_pkg::rsp_type rsp_data
);

   logic                           accept;
   logic                           push;
   logic [CHANNEL_COUNT-1:0][15:0] push_frame;
   logic                           pop;
   logic                           head_valid;
   logic [CHANNEL_COUNT-1:0][15:0] head_frame;
   logic                           q_full;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   pfp_front #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .FRAME_BYTES   (FRAME_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .frame    (push_frame)
   );

   pfp_queue #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head_valid (head_valid),
      .head_frame (head_frame),
      .full       (q_full)
   );

   pfp_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (head_valid),
      .q_frame   (head_frame),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pwm_frame_parser: streams bytes in and checks the channel results.
// Depends on pfp_pkg and the parser RTL. Every result is predicted here and checked field by field.
module testbench;

   localparam int CHANNEL_COUNT = pfp_pkg::CHANNEL_COUNT;
   localparam int FRAME_BYTES   = pfp_pkg::FRAME_BYTES;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [7:0] LEN_BYTE = 8'(2 * CHANNEL_COUNT);

   typedef enum int {BREAK_SOF_A, BREAK_SOF_B, BREAK_ID, BREAK_LEN, BREAK_SUM} frame_fault_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pfp_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pfp_pkg::rsp_type rsp_data;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int frames_decoded  = 0;
   int mismatches      = 0;
   int cycle_count     = 0;

   // predicted parser state
   logic [7:0] scan_window [FRAME_BYTES];
   int         scan_fill = 0;

   logic [15:0]      channel_vals [CHANNEL_COUNT];
   logic [7:0]       frame_buf [FRAME_BYTES];
   pfp_pkg::rsp_type expected_channels [$];

   pwm_frame_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  expected_channels.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // (raw - 5000) / 5000 in Q1.15, clamped, rounded to nearest
   function automatic logic [15:0] duty_from_raw(input logic [15:0] raw);
      int delta;
      int mag;
      int steps;
      delta = int'(raw) - 5000;
      if (delta >= 5000) return 16'h7FFF;
      if (delta <= -5000) return 16'h8000;
      mag = (delta < 0) ? -delta : delta;
      steps = (mag * 4096 + 312) / 625;
      return (delta < 0) ? 16'(-steps) : 16'(steps);
   endfunction

   task automatic predict_byte(input pfp_pkg::req_type item);
      pfp_pkg::rsp_type chan;
      logic [7:0]       sum;
      bit               good;
      int               i;
      if (scan_fill >= FRAME_BYTES) scan_fill = 0;
      scan_window[scan_fill] = item.data_byte;
      scan_fill++;
      if (scan_fill == FRAME_BYTES) begin
         sum = '0;
         for (i = 0; i < FRAME_BYTES - 1; i++) sum += scan_window[i];
         good = scan_window[0] == pfp_pkg::SOF_A && scan_window[1] == pfp_pkg::SOF_B &&
                scan_window[2] == pfp_pkg::HEADER_ID && scan_window[3] == LEN_BYTE &&
                sum == scan_window[FRAME_BYTES - 1];
         if (good) begin
            for (i = 0; i < CHANNEL_COUNT; i++) begin
               chan.channel_index = 3'(i);
               chan.raw_value     = {scan_window[4 + 2 * i], scan_window[5 + 2 * i]};
               chan.duty_q15      = duty_from_raw(chan.raw_value);
               chan.last_channel  = (i == CHANNEL_COUNT - 1);
               expected_channels.push_back(chan);
            end
            scan_fill = 0;
         end else begin
            // drop the oldest byte and keep scanning
            for (i = 0; i < FRAME_BYTES - 1; i++) scan_window[i] = scan_window[i + 1];
            scan_fill--;
         end
      end
      if (item.burst_end) scan_fill = 0;
   endtask

   task automatic send_item(input logic [7:0] data, input logic end_burst);
      pfp_pkg::req_type item;
      item.data_byte = data;
      item.burst_end = end_burst;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_byte(item);
      items_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_channels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic build_frame();
      logic [7:0] sum;
      int         i;
      frame_buf[0] = pfp_pkg::SOF_A;
      frame_buf[1] = pfp_pkg::SOF_B;
      frame_buf[2] = pfp_pkg::HEADER_ID;
      frame_buf[3] = LEN_BYTE;
      for (i = 0; i < CHANNEL_COUNT; i++) begin
         frame_buf[4 + 2 * i] = channel_vals[i][15:8];
         frame_buf[5 + 2 * i] = channel_vals[i][7:0];
      end
      sum = '0;
      for (i = 0; i < FRAME_BYTES - 1; i++) sum += frame_buf[i];
      frame_buf[FRAME_BYTES - 1] = sum;
   endtask

   task automatic send_frame_bytes(input int count, input logic end_burst);
      int i;
      for (i = 0; i < count; i++) send_item(frame_buf[i], end_burst && i == count - 1);
   endtask

   // bias toward the clamp edges and the center of the duty range
   function automatic logic [15:0] pick_raw();
      unique case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'(4996 + $urandom_range(8));
         3: return 16'(9998 + $urandom_range(4));
         4: return 16'($urandom_range(3));
         5: return 16'($urandom_range(10000));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic randomize_channels();
      int i;
      for (i = 0; i < CHANNEL_COUNT; i++) channel_vals[i] = pick_raw();
   endtask

   task automatic test_extremes();
      // a stray byte first forces one slide before the frame lines up;
      // the frame ends on the same byte as the burst
      channel_vals = '{16'd0, 16'd1, 16'd4999, 16'd5000, 16'd5001, 16'd9999, 16'd10000,
                       16'hFFFF};
      build_frame();
      send_item(8'h00, 1'b0);
      send_frame_bytes(FRAME_BYTES, 1'b1);
      wait_for_results();
   endtask

   task automatic test_partial_burst();
      send_item(pfp_pkg::SOF_A, 1'b0);
      send_item(pfp_pkg::SOF_B, 1'b0);
      send_item(pfp_pkg::HEADER_ID, 1'b1);
   endtask

   task automatic test_broken_frame(input logic end_burst);
      frame_fault_type fault;
      logic [7:0]      flip;
      logic [7:0]      sum;
      int              i;
      randomize_channels();
      build_frame();
      fault = frame_fault_type'($urandom_range(4));
      flip  = 8'($urandom_range(1, 255));
      unique case (fault)
         BREAK_SOF_A: frame_buf[0] ^= flip;
         BREAK_SOF_B: frame_buf[1] ^= flip;
         BREAK_ID:    frame_buf[2] ^= flip;
         BREAK_LEN:   frame_buf[3] ^= flip;
         BREAK_SUM:   frame_buf[FRAME_BYTES - 1] ^= flip;
      endcase
      // keep the sum consistent so only the header field is wrong
      if (fault != BREAK_SUM) begin
         sum = '0;
         for (i = 0; i < FRAME_BYTES - 1; i++) sum += frame_buf[i];
         frame_buf[FRAME_BYTES - 1] = sum;
      end
      send_frame_bytes(FRAME_BYTES, end_burst);
   endtask

   task automatic test_random_stream(input int idle_pct, input int stall_pct, input int target);
      int roll;
      int count;
      int i;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      while (items_sent < target) begin
         roll = $urandom_range(99);
         if (roll < 55) begin
            randomize_channels();
            build_frame();
            send_frame_bytes(FRAME_BYTES, $urandom_range(3) == 0);
         end else if (roll < 70) begin
            test_broken_frame($urandom_range(2) == 0);
         end else if (roll < 80) begin
            randomize_channels();
            build_frame();
            send_frame_bytes($urandom_range(1, FRAME_BYTES - 1), 1'b1);
         end else if (roll < 90) begin
            count = $urandom_range(1, 5);
            for (i = 0; i < count; i++) send_item(8'($urandom), $urandom_range(7) == 0);
         end else begin
            // false start: a header that goes nowhere, then the scan must slide past it
            send_item(pfp_pkg::SOF_A, 1'b0);
            if ($urandom_range(1)) send_item(pfp_pkg::SOF_B, 1'b0);
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      pfp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_channels.size() == 0) begin
            report_mismatch($sformatf("unexpected result: channel %0d raw %0d",
                                      rsp_data.channel_index, rsp_data.raw_value));
         end else begin
            want = expected_channels.pop_front();
            if (rsp_data.channel_index !== want.channel_index)
               report_mismatch($sformatf("channel_index %0d, wanted %0d",
                                         rsp_data.channel_index, want.channel_index));
            if (rsp_data.raw_value !== want.raw_value)
               report_mismatch($sformatf("raw_value %0d, wanted %0d",
                                         rsp_data.raw_value, want.raw_value));
            if (rsp_data.duty_q15 !== want.duty_q15)
               report_mismatch($sformatf("duty_q15 %0d, wanted %0d (raw %0d)",
                                         rsp_data.duty_q15, want.duty_q15, want.raw_value));
            if (rsp_data.last_channel !== want.last_channel)
               report_mismatch($sformatf("last_channel %0b, wanted %0b on channel %0d",
                                         rsp_data.last_channel, want.last_channel,
                                         want.channel_index));
            results_checked++;
            if (want.last_channel) frames_decoded++;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_partial_burst();
      test_random_stream(0, 0, 130);
      // hold the sender until every channel of the backlog is out
      wait_for_results();
      test_random_stream(77, 0, 230);
      test_random_stream(0, 77, 330);
      test_random_stream(14, 14, 430);
      wait_for_results();

      $display("run covered %0d bytes in, %0d frames decoded, %0d channel results checked",
               items_sent, frames_decoded, results_checked);
      $display("stream held good, broken, partial and noisy frames under four idle patterns");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
